>>> rtl/console_bus_decoder_with_ram_assert.svh
// ----------------------------------------------------------------------------
// console bus decoder assertion macros
// shared assertion shorthands, sampled on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CONSOLE_BUS_DECODER_WITH_RAM_ASSERT_SVH
`define CONSOLE_BUS_DECODER_WITH_RAM_ASSERT_SVH

// same-cycle implication
`define CBD_ASSERT_SAME(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CBD_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// console bus decoder package
// shared constants, address map, target codes, state and control types
// ----------------------------------------------------------------------------
package cbd_pkg;

   // default work ram depth in bytes
   localparam int RAM_DEPTH_DEF = 2048;

   // mirrored ram window address bits
   localparam int RAM_WIN_W = 13;

   // reciprocal scaling for the ram index modulo
   localparam int IDX_SHIFT  = 26;
   localparam int IDX_PROD_W = 40;

   // address map
   localparam logic [15:0] ADDR_RAM_LAST     = 16'h1FFF;
   localparam logic [15:0] ADDR_VIDEO_LAST   = 16'h3FFF;
   localparam logic [15:0] ADDR_SOUND_LAST   = 16'h4013;
   localparam logic [15:0] ADDR_SPRITE_DMA   = 16'h4014;
   localparam logic [15:0] ADDR_SOUND_STATUS = 16'h4015;
   localparam logic [15:0] ADDR_PAD_ZERO     = 16'h4016;
   localparam logic [15:0] ADDR_PAD_ONE      = 16'h4017;

   // target codes
   typedef enum logic [2:0] {
      TGT_CART  = 3'd0,
      TGT_RAM   = 3'd1,
      TGT_VIDEO = 3'd2,
      TGT_SOUND = 3'd3,
      TGT_DMA   = 3'd4,
      TGT_PAD   = 3'd5,
      TGT_NONE  = 3'd6
   } cbd_target_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_FIX,
      ST_RESULT
   } cbd_state_type;

   // ram port control
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } cbd_ram_ctl_type;

endpackage

>>> rtl/console_bus_decoder_with_ram.sv
// ----------------------------------------------------------------------------
// console_bus_decoder_with_ram
// cpu bus address decoder with mirrored work ram and controller shifters
// ----------------------------------------------------------------------------
// One request is one cpu bus read or write; each gives exactly one response.
// A new request is taken only once the sequencer has returned to idle; each
// passes through the ram index unit (reciprocal multiply, back-multiply and
// correction, two register stages) and then the single ram port with its
// registered read. A finished response sits in the output register while the
// next request is taken; a response that is not taken holds the sequencer
// in its last step. After reset the work ram is zeroed by a sweep over every
// address, during which req_tready is low.
// ----------------------------------------------------------------------------
module console_bus_decoder_with_ram #(
   parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // address, write_data, cart_read_data, video_read_data,
   // pad_zero_buttons, pad_one_buttons
   input  logic [55:0] req_tdata,
   // action, cart_claims
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data, target, device_register, dma_page
   output logic [23:0] rsp_tdata,
   // dma_start
   output logic        rsp_tuser
);

`include "console_bus_decoder_with_ram_assert.svh"

   localparam int AW = $clog2(RAM_DEPTH);

   // request fields
   logic        is_write;
   logic        claimed;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [7:0]  cart_data;
   logic [7:0]  video_data;
   logic [7:0]  pad_zero;
   logic [7:0]  pad_one;

   assign is_write   = req_tuser[0];
   assign claimed    = req_tuser[1];
   assign address    = req_tdata[15:0];
   assign write_data = req_tdata[23:16];
   assign cart_data  = req_tdata[31:24];
   assign video_data = req_tdata[39:32];
   assign pad_zero   = req_tdata[47:40];
   assign pad_one    = req_tdata[55:48];

   cbd_pkg::cbd_state_type   state_ff;
   cbd_pkg::cbd_state_type   state_in;
   cbd_pkg::cbd_ram_ctl_type ram_ctl;
   logic                     accept;
   logic                     out_load;
   logic                     clear_busy;
   logic [AW-1:0]            ram_index;
   logic [7:0]               ram_rd_data;

   // decoded request, held through the sequence
   cbd_pkg::cbd_target_type  target_ff;
   cbd_pkg::cbd_target_type  target_in;
   logic [4:0]               dev_reg_ff;
   logic [4:0]               dev_reg_in;
   logic                     dma_start_ff;
   logic                     dma_start_in;
   logic [7:0]               dma_page_ff;
   logic [7:0]               dma_page_in;
   logic [7:0]               rdata_ff;
   logic [7:0]               rdata_in;
   logic                     ram_acc_ff;
   logic                     ram_acc_in;
   logic                     write_ff;
   logic [7:0]               wdata_ff;

   // controller shifters
   logic [7:0]               pad_shift_ff [2];
   logic                     pad_latch;
   logic                     pad_read;

   // response register
   logic                     rsp_valid_ff;
   logic [7:0]               rsp_rdata_ff;
   cbd_pkg::cbd_target_type  rsp_target_ff;
   logic [4:0]               rsp_reg_ff;
   logic                     rsp_dstart_ff;
   logic [7:0]               rsp_dpage_ff;

   // address decode
   always_comb begin
      target_in    = cbd_pkg::TGT_NONE;
      dev_reg_in   = '0;
      dma_start_in = 1'b0;
      dma_page_in  = '0;
      rdata_in     = '0;
      ram_acc_in   = 1'b0;
      pad_latch    = 1'b0;
      pad_read     = 1'b0;
      priority if (claimed) begin
         target_in = cbd_pkg::TGT_CART;
         if (!is_write) begin
            rdata_in = cart_data;
         end
      end else if (address <= cbd_pkg::ADDR_RAM_LAST) begin
         target_in  = cbd_pkg::TGT_RAM;
         ram_acc_in = 1'b1;
      end else if (address <= cbd_pkg::ADDR_VIDEO_LAST) begin
         target_in  = cbd_pkg::TGT_VIDEO;
         dev_reg_in = {2'b00, address[2:0]};
         if (!is_write) begin
            rdata_in = video_data;
         end
      end else if (is_write) begin
         priority if (address <= cbd_pkg::ADDR_SOUND_LAST ||
                      address == cbd_pkg::ADDR_SOUND_STATUS ||
                      address == cbd_pkg::ADDR_PAD_ONE) begin
            target_in  = cbd_pkg::TGT_SOUND;
            dev_reg_in = address[4:0];
         end else if (address == cbd_pkg::ADDR_SPRITE_DMA) begin
            target_in    = cbd_pkg::TGT_DMA;
            dma_start_in = 1'b1;
            dma_page_in  = write_data;
         end else if (address == cbd_pkg::ADDR_PAD_ZERO) begin
            target_in = cbd_pkg::TGT_PAD;
            pad_latch = 1'b1;
         end else begin
            target_in = cbd_pkg::TGT_NONE;
         end
      end else if (address == cbd_pkg::ADDR_PAD_ZERO ||
                   address == cbd_pkg::ADDR_PAD_ONE) begin
         target_in = cbd_pkg::TGT_PAD;
         pad_read  = 1'b1;
         rdata_in  = {7'b0, pad_shift_ff[address[0]][7]};
      end else begin
         target_in = cbd_pkg::TGT_NONE;
      end
   end

   // decoded request registers
   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff    <= target_in;
         dev_reg_ff   <= dev_reg_in;
         dma_start_ff <= dma_start_in;
         dma_page_ff  <= dma_page_in;
         rdata_ff     <= rdata_in;
         ram_acc_ff   <= ram_acc_in;
         write_ff     <= is_write;
         wdata_ff     <= write_data;
      end
   end

   // controller latch and shift
   always_ff @(posedge clock) begin
      if (reset) begin
         pad_shift_ff[0] <= '0;
         pad_shift_ff[1] <= '0;
      end else if (accept && pad_latch) begin
         pad_shift_ff[0] <= pad_zero;
         pad_shift_ff[1] <= pad_one;
      end else if (accept && pad_read) begin
         pad_shift_ff[address[0]] <= {pad_shift_ff[address[0]][6:0], 1'b0};
      end
   end

   // ram index unit
   cbd_index #(
      .RAM_DEPTH (RAM_DEPTH)
   ) u_index (
      .clock     (clock),
      .load      (accept),
      .win_addr  (address[cbd_pkg::RAM_WIN_W-1:0]),
      .ram_index (ram_index)
   );

   // work ram
   cbd_ram #(
      .RAM_DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ram_ctl),
      .addr       (ram_index),
      .wr_data    (wdata_ff),
      .rd_data    (ram_rd_data),
      .clear_busy (clear_busy)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer next state and controls
   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      ram_ctl.wr_en = 1'b0;
      ram_ctl.rd_en = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         cbd_pkg::ST_IDLE: begin
            req_tready = !clear_busy;
            if (req_tvalid && !clear_busy) begin
               state_in = cbd_pkg::ST_MOD;
            end
         end
         cbd_pkg::ST_MOD: begin
            state_in = cbd_pkg::ST_FIX;
         end
         cbd_pkg::ST_FIX: begin
            ram_ctl.wr_en = ram_acc_ff & write_ff;
            ram_ctl.rd_en = ram_acc_ff & !write_ff;
            state_in      = cbd_pkg::ST_RESULT;
         end
         cbd_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = cbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbd_pkg::ST_IDLE;
         end
      endcase
   end

   assign accept = req_tvalid & req_tready;

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rdata_ff  <= (ram_acc_ff && !write_ff) ? ram_rd_data : rdata_ff;
         rsp_target_ff <= target_ff;
         rsp_reg_ff    <= dev_reg_ff;
         rsp_dstart_ff <= dma_start_ff;
         rsp_dpage_ff  <= dma_page_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dpage_ff, rsp_reg_ff, rsp_target_ff, rsp_rdata_ff};
   assign rsp_tuser  = rsp_dstart_ff;

   // checks
   `CBD_ASSERT_NEXT(a_accept_starts_seq, accept, state_ff == cbd_pkg::ST_MOD)
   `CBD_ASSERT_SAME(a_clear_quiet, clear_busy,
                    state_ff == cbd_pkg::ST_IDLE && !rsp_valid_ff)
   `CBD_ASSERT_SAME(a_dma_only_dma, rsp_valid_ff && rsp_dstart_ff,
                    rsp_target_ff == cbd_pkg::TGT_DMA)
   `CBD_ASSERT_SAME(a_reg_only_dev, rsp_valid_ff && rsp_reg_ff != 5'd0,
                    rsp_target_ff == cbd_pkg::TGT_VIDEO ||
                    rsp_target_ff == cbd_pkg::TGT_SOUND)

endmodule

>>> rtl/cbd_index.sv
// ----------------------------------------------------------------------------
// cbd_index
// ram index unit: mirrored window address modulo the ram depth, via a
// reciprocal multiply, a back-multiply and one correction step
// ----------------------------------------------------------------------------
module cbd_index #(
   parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic [cbd_pkg::RAM_WIN_W-1:0]  win_addr,
   output logic [$clog2(RAM_DEPTH)-1:0]   ram_index
);

   localparam int AW    = $clog2(RAM_DEPTH);
   localparam int RW    = AW + 1;
   localparam int QMAX  = ((1 << cbd_pkg::RAM_WIN_W) - 1) / RAM_DEPTH;
   localparam int QW    = (QMAX == 0) ? 1 : $clog2(QMAX + 1);
   localparam int RECIP = (1 << cbd_pkg::IDX_SHIFT) / RAM_DEPTH;
   localparam int XW    = cbd_pkg::RAM_WIN_W + 1;

   logic [cbd_pkg::RAM_WIN_W-1:0]  x_ff;
   logic [QW-1:0]                  q_ff;
   logic [QW-1:0]                  q_in;
   logic [RW-1:0]                  r_ff;
   logic [RW-1:0]                  r_in;
   logic [cbd_pkg::IDX_PROD_W-1:0] q_prod;
   logic [XW-1:0]                  back_prod;
   logic [XW-1:0]                  diff;

   // quotient estimate, at most one below the true quotient
   assign q_prod = cbd_pkg::IDX_PROD_W'(win_addr) * cbd_pkg::IDX_PROD_W'(RECIP);
   assign q_in   = q_prod[cbd_pkg::IDX_SHIFT +: QW];

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= win_addr;
         q_ff <= q_in;
      end
   end

   // partial remainder, below twice the depth
   assign back_prod = XW'(q_ff) * XW'(RAM_DEPTH);
   assign diff      = XW'(x_ff) - back_prod;
   assign r_in      = diff[RW-1:0];

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   // final correction
   always_comb begin
      if (r_ff >= RW'(RAM_DEPTH)) begin
         ram_index = AW'(r_ff - RW'(RAM_DEPTH));
      end else begin
         ram_index = r_ff[AW-1:0];
      end
   end

endmodule

>>> rtl/cbd_ram.sv
// ----------------------------------------------------------------------------
// cbd_ram
// work ram, one port, registered read, with a zeroing sweep after reset
// ----------------------------------------------------------------------------
module cbd_ram #(
   parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cbd_pkg::cbd_ram_ctl_type      ctl,
   input  logic [$clog2(RAM_DEPTH)-1:0]  addr,
   input  logic [7:0]                    wr_data,
   output logic [7:0]                    rd_data,
   output logic                          clear_busy
);

   localparam int AW = $clog2(RAM_DEPTH);

   logic [7:0]    ram_ff [RAM_DEPTH];
   logic [7:0]    rd_data_ff;
   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_byte;

   // clearing sweep control
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(RAM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port shared between sweep and accesses
   assign wr_en   = clr_busy_ff | ctl.wr_en;
   assign wr_addr = clr_busy_ff ? clr_addr_ff : addr;
   assign wr_byte = clr_busy_ff ? 8'h00 : wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_byte;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= ram_ff[addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

>>> test/tb_console_bus_decoder_with_ram.sv
// ----------------------------------------------------------------------------
// console bus decoder testbench
// drives cpu bus reads and writes into the decoder, predicts each response
// with a local model of the address map, work ram and controller shifters,
// and checks every response field in order under random idling and stalls
// ----------------------------------------------------------------------------
module tb_console_bus_decoder_with_ram;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAM_DEPTH   = cbd_pkg::RAM_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 16;
   localparam int HOLD_OFF    = 400;
   localparam int MAX_REPORTS = 10;

   // one cpu bus access as it enters the block
   typedef struct packed {
      logic        is_write;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic        claimed;
      logic [7:0]  cart_data;
      logic [7:0]  video_data;
      logic [7:0]  pad0;
      logic [7:0]  pad1;
   } bus_access_type;

   // one decoded response
   typedef struct packed {
      logic [7:0]              rdata;
      cbd_pkg::cbd_target_type tgt;
      logic [4:0]              dev_reg;
      logic                    dma_go;
      logic [7:0]              dma_page;
   } bus_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;  // address, write_data, cart_read_data,
                                 // video_read_data, pad_zero_buttons, pad_one_buttons
   logic [1:0]  req_tuser = '0;  // action, cart_claims
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // read_data, target, device_register, dma_page
   logic        rsp_tuser;       // dma_start

   // local image of the block state
   logic [7:0]  ram_image [RAM_DEPTH];
   logic [7:0]  pad_shift_image [2];

   bus_result_type pending_results [$];

   int          cycle_count = 0;
   int          sent_count = 0;
   int          checked_count = 0;
   int          error_count = 0;
   int          hits_per_target [7];

   // sender pacing
   int          burst_left = 0;
   int          burst_max = 8;
   int          gap_max = 6;

   // receiver pacing
   int          rsp_mode = 0;
   int          run_left = 0;
   int          hold_off_left = 0;

   console_bus_decoder_with_ram #(.RAM_DEPTH(RAM_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   // decode one access against the local state and update that state
   function automatic bus_result_type decode_access(input bus_access_type a);
      bus_result_type r;
      int             idx;
      int             p;
      r = '{rdata: 8'h00, tgt: cbd_pkg::TGT_NONE, dev_reg: 5'd0, dma_go: 1'b0,
            dma_page: 8'h00};
      if (a.claimed) begin
         r.tgt = cbd_pkg::TGT_CART;
         if (!a.is_write) r.rdata = a.cart_data;
      end else if (a.addr <= cbd_pkg::ADDR_RAM_LAST) begin
         idx = int'(a.addr & 16'h1FFF) % RAM_DEPTH;
         r.tgt = cbd_pkg::TGT_RAM;
         if (a.is_write) ram_image[idx] = a.wdata;
         else r.rdata = ram_image[idx];
      end else if (a.addr <= cbd_pkg::ADDR_VIDEO_LAST) begin
         r.tgt = cbd_pkg::TGT_VIDEO;
         r.dev_reg = 5'(a.addr & 16'h0007);
         if (!a.is_write) r.rdata = a.video_data;
      end else if (a.is_write) begin
         if (a.addr <= cbd_pkg::ADDR_SOUND_LAST || a.addr == cbd_pkg::ADDR_SOUND_STATUS ||
             a.addr == cbd_pkg::ADDR_PAD_ONE) begin
            r.tgt = cbd_pkg::TGT_SOUND;
            r.dev_reg = 5'(a.addr - 16'h4000);
         end else if (a.addr == cbd_pkg::ADDR_SPRITE_DMA) begin
            r.tgt = cbd_pkg::TGT_DMA;
            r.dma_go = 1'b1;
            r.dma_page = a.wdata;
         end else if (a.addr == cbd_pkg::ADDR_PAD_ZERO) begin
            r.tgt = cbd_pkg::TGT_PAD;
            pad_shift_image[0] = a.pad0;
            pad_shift_image[1] = a.pad1;
         end
      end else if (a.addr == cbd_pkg::ADDR_PAD_ZERO || a.addr == cbd_pkg::ADDR_PAD_ONE) begin
         p = int'(a.addr[0]);
         r.tgt = cbd_pkg::TGT_PAD;
         r.rdata = {7'd0, pad_shift_image[p][7]};
         pad_shift_image[p] = {pad_shift_image[p][6:0], 1'b0};
      end
      return r;
   endfunction

   // access with the given kind, address and byte; no cartridge claim, other side inputs random
   function automatic bus_access_type make_access(input logic w, input logic [15:0] addr,
                                                  input logic [7:0] wdata);
      bus_access_type a;
      a.is_write   = w;
      a.addr       = addr;
      a.wdata      = wdata;
      a.claimed    = 1'b0;
      a.cart_data  = 8'($urandom);
      a.video_data = 8'($urandom);
      a.pad0       = 8'($urandom);
      a.pad1       = 8'($urandom);
      return a;
   endfunction

   // offer one request, wait for it to be taken, then pace the sender
   task automatic send_access(input bus_access_type a);
      req_tdata  = {a.pad1, a.pad0, a.video_data, a.cart_data, a.wdata, a.addr};
      req_tuser  = {a.claimed, a.is_write};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(decode_access(a));
      sent_count++;
      @(negedge clock);
      if (gap_max == 0 || burst_left > 0) begin
         if (burst_left > 0) burst_left--;
      end else begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, gap_max)) @(negedge clock);
         burst_left = $urandom_range(0, burst_max);
      end
   endtask

   // receiver: long hold-off first, then the selected stall pattern
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         case (rsp_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               // alternating runs of ready and stall
               if (run_left == 0) begin
                  rsp_tready <= ~rsp_tready;
                  run_left <= rsp_tready ? $urandom_range(1, 12) : $urandom_range(1, 8);
               end else begin
                  run_left <= run_left - 1;
               end
            end
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      bus_result_type want;
      bus_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rdata    = rsp_tdata[7:0];
         got.tgt      = cbd_pkg::cbd_target_type'(rsp_tdata[10:8]);
         got.dev_reg  = rsp_tdata[15:11];
         got.dma_go   = rsp_tuser;
         got.dma_page = rsp_tdata[23:16];
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected response at cycle %0d: data %02h target %0d",
                        cycle_count, got.rdata, got.tgt);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (int'(want.tgt) < 7) hits_per_target[int'(want.tgt)]++;
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"mismatch on response %0d: expected data %02h target %0d ",
                            "reg %0d dma %0b page %02h, got data %02h target %0d ",
                            "reg %0d dma %0b page %02h"},
                           checked_count, want.rdata, want.tgt, want.dev_reg,
                           want.dma_go, want.dma_page, got.rdata, got.tgt,
                           got.dev_reg, got.dma_go, got.dma_page);
            end
         end
      end
   end

   // address map corners, every target but the pads, and cartridge claims
   task automatic test_address_map();
      bus_access_type a;
      send_access(make_access(1'b0, 16'h0000, 8'h00));
      send_access(make_access(1'b1, 16'h0005, 8'hA5));
      send_access(make_access(1'b0, 16'h1805, 8'h00));
      send_access(make_access(1'b1, 16'h1FFF, 8'hFF));
      send_access(make_access(1'b0, 16'h07FF, 8'h00));
      send_access(make_access(1'b0, 16'h2000, 8'h00));
      send_access(make_access(1'b1, 16'h3FFF, 8'h3C));
      send_access(make_access(1'b1, 16'h4000, 8'h01));
      send_access(make_access(1'b1, 16'h4013, 8'h7F));
      send_access(make_access(1'b1, 16'h4015, 8'h0F));
      send_access(make_access(1'b1, 16'h4017, 8'hC0));
      send_access(make_access(1'b1, cbd_pkg::ADDR_SPRITE_DMA, 8'h02));
      send_access(make_access(1'b0, cbd_pkg::ADDR_SPRITE_DMA, 8'h00));
      send_access(make_access(1'b0, cbd_pkg::ADDR_SOUND_STATUS, 8'h00));
      send_access(make_access(1'b1, 16'hFFFF, 8'hFF));
      send_access(make_access(1'b0, 16'hFFFF, 8'h00));
      // cartridge takes a read and a write; ram must stay untouched
      a = make_access(1'b0, 16'h0005, 8'h00);
      a.claimed = 1'b1;
      send_access(a);
      a = make_access(1'b1, 16'h0005, 8'h11);
      a.claimed = 1'b1;
      send_access(a);
      send_access(make_access(1'b0, 16'h0805, 8'h00));
   endtask

   // latch both pads, then shift part of each out with reads
   task automatic test_controller_shift();
      bus_access_type a;
      a = make_access(1'b1, cbd_pkg::ADDR_PAD_ZERO, 8'h00);
      a.pad0 = 8'h81;
      a.pad1 = 8'hFF;
      send_access(a);
      repeat (3) begin
         send_access(make_access(1'b0, cbd_pkg::ADDR_PAD_ZERO, 8'h00));
         send_access(make_access(1'b0, cbd_pkg::ADDR_PAD_ONE, 8'h00));
      end
   endtask

   // random access weighted toward the decoded regions
   function automatic bus_access_type random_access();
      bus_access_type a;
      int             pick;
      logic [15:0]    addr;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // small pool so writes are read back through the mirrors
         if ($urandom_range(0, 1)) addr = 16'(($urandom_range(0, 3) << 11) |
                                               $urandom_range(0, 63));
         else addr = 16'($urandom_range(0, 16'h1FFF));
      end else if (pick < 45) begin
         addr = 16'($urandom_range(16'h2000, 16'h3FFF));
      end else if (pick < 65) begin
         addr = 16'h4000 + 16'($urandom_range(0, 31));
      end else if (pick < 75) begin
         addr = 16'($urandom_range(16'h4018, 16'hFFFF));
      end else begin
         addr = 16'($urandom);
      end
      a = make_access(1'($urandom_range(0, 1)), addr, 8'($urandom));
      a.claimed = ($urandom_range(0, 9) == 0);
      return a;
   endfunction

   // mixed traffic with pad latch and shift sequences
   task automatic test_random_traffic(input int item_goal);
      int start;
      int n;
      start = sent_count;
      while (sent_count - start < item_goal) begin
         // change pacing every so often, including stretches with no idling
         if ($urandom_range(0, 49) == 0) begin
            rsp_mode = $urandom_range(0, 2);
            gap_max  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         end
         if ($urandom_range(0, 6) == 0) begin
            send_access(make_access(1'b1, cbd_pkg::ADDR_PAD_ZERO, 8'($urandom)));
            n = $urandom_range(1, 10);
            repeat (n)
               send_access(make_access(1'b0, $urandom_range(0, 1) ? cbd_pkg::ADDR_PAD_ONE
                                                                 : cbd_pkg::ADDR_PAD_ZERO,
                                       8'($urandom)));
         end else begin
            send_access(random_access());
         end
      end
   endtask

   // receiver holds off while the sender keeps offering requests
   task automatic test_backpressure();
      req_tvalid = 1'b0;
      gap_max = 0;
      rsp_mode = 0;
      @(posedge clock);
      hold_off_left = HOLD_OFF;
      @(negedge clock);
      repeat (40) send_access(random_access());
      gap_max = 6;
      rsp_mode = 2;
   endtask

   initial begin
      // block state after reset: ram and shifters cleared
      foreach (ram_image[i]) ram_image[i] = 8'h00;
      pad_shift_image[0] = 8'h00;
      pad_shift_image[1] = 8'h00;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_address_map();
      test_controller_shift();
      test_random_traffic(450);
      test_backpressure();
      test_random_traffic(360);

      // drain and let any late response show up
      req_tvalid = 1'b0;
      rsp_mode = 1;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d requests, checked %0d responses, %0d errors",
               sent_count, checked_count, error_count);
      $display("targets cart %0d ram %0d video %0d sound %0d dma %0d pad %0d none %0d",
               hits_per_target[0], hits_per_target[1], hits_per_target[2],
               hits_per_target[3], hits_per_target[4], hits_per_target[5],
               hits_per_target[6]);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
